>>> rtl/truetype_simple_glyph_decoder_macros.svh
// Assertion macros shared by the RTL.
`ifndef TRUETYPE_SIMPLE_GLYPH_DECODER_MACROS_SVH
`define TRUETYPE_SIMPLE_GLYPH_DECODER_MACROS_SVH

`define TSGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tsgd_pkg.sv
package tsgd_pkg;

    localparam int CntW = 7;

    localparam int FlagOnCurve = 0;
    localparam int FlagXShort  = 1;
    localparam int FlagYShort  = 2;
    localparam int FlagRepeat  = 3;
    localparam int FlagXSame   = 4;
    localparam int FlagYSame   = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENDS,
        ST_ILEN,
        ST_SKIP,
        ST_FLAGS,
        ST_REPCNT,
        ST_REPFILL,
        ST_FETCH,
        ST_LOOK,
        ST_DATA
    } t_state;

endpackage

>>> rtl/truetype_simple_glyph_decoder.sv
// Simple glyph decoder for TrueType outline data.
// Input channel: i_in_valid / o_in_stall. An item is either a glyph start
// (i_glyph_start high, with i_contour_count) or one data byte of the glyph.
// Output channel: o_out_valid / i_out_stall, one item per point of the glyph,
// or a single item without a point for an empty glyph or an error.
// Header, instruction and flag bytes are taken as they arrive. A flag repeat
// count is taken, then the repeated flags are written without taking input.
// In the coordinate phases every point starts with a lookup of its flag and
// stored x in the point memories, through the fetch and look states, then takes
// its delta bytes, and each of the x and y passes ends with one more fetch state.
// A point's result is valid in the cycle after its last byte is taken.
// Points without delta bytes are produced without taking input.
// Reset returns the block to idle with no glyph open; data bytes that arrive
// while idle are taken and dropped. The point memories are not cleared.
// A stalled receiver holds the result register, and the block stops taking
// items until that result leaves. A glyph start abandons any open glyph.
`include "truetype_simple_glyph_decoder_macros.svh"

module truetype_simple_glyph_decoder #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_glyph_start,
    input  logic [6:0]  i_contour_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_point_index,
    output logic signed [15:0] o_x_coord,
    output logic signed [15:0] o_y_coord,
    output logic        o_curve_on,
    output logic        o_point_valid,
    output logic        o_decode_error,
    output logic        o_last_point
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [15:0] MaxPts16 = 16'(MAX_POINTS);
    localparam logic [tsgd_pkg::CntW-1:0] MaxCnt = tsgd_pkg::CntW'(MAX_CONTOURS);
    localparam logic [tsgd_pkg::CntW-1:0] MaxTot = tsgd_pkg::CntW'(MAX_POINTS);

    tsgd_pkg::t_state r_state, n_state;
    logic r_hi, n_hi, r_is_y, n_is_y;
    logic [tsgd_pkg::CntW-1:0] r_contours, n_contours, r_max, n_max;
    logic [tsgd_pkg::CntW-1:0] r_total, n_total, r_cursor, n_cursor;
    logic [7:0]  r_hold, n_hold, r_rep, n_rep, r_last_flag, n_last_flag;
    logic [15:0] r_skip, n_skip, r_sum, n_sum;

    logic [7:0]  flag_mem [MAX_POINTS];
    logic [15:0] x_mem [MAX_POINTS];
    logic [7:0]  r_rd_flag;
    logic [15:0] r_rd_x;

    logic        out_free, takes, in_acc;
    logic        fw_en, xw_en, rd_en;
    logic [7:0]  fw_data;
    logic [15:0] xw_data;
    logic        emit, e_pv, e_err, e_last, e_on;
    logic [15:0] e_x, e_y;

    logic        sb, mb;
    logic [15:0] word, sum_short, sum_long;
    logic [tsgd_pkg::CntW-1:0] max_new, cur_inc;

    always_comb begin
        out_free = !o_out_valid || !i_out_stall;
        case (r_state)
            tsgd_pkg::ST_REPFILL, tsgd_pkg::ST_FETCH, tsgd_pkg::ST_LOOK: takes = 1'b0;
            default: takes = 1'b1;
        endcase
        o_in_stall = !(takes && out_free);
        in_acc = i_in_valid && !o_in_stall;
    end

    always_comb begin
        word      = {r_hold, i_data_byte};
        sb        = r_is_y ? r_rd_flag[tsgd_pkg::FlagYShort] : r_rd_flag[tsgd_pkg::FlagXShort];
        mb        = r_is_y ? r_rd_flag[tsgd_pkg::FlagYSame] : r_rd_flag[tsgd_pkg::FlagXSame];
        sum_short = mb ? r_sum + {8'd0, i_data_byte} : r_sum - {8'd0, i_data_byte};
        sum_long  = r_sum + word;
        max_new   = (word[tsgd_pkg::CntW-1:0] > r_max) ? word[tsgd_pkg::CntW-1:0] : r_max;
        cur_inc   = r_cursor + 1'b1;

        n_state = r_state;     n_hi = r_hi;         n_is_y = r_is_y;
        n_contours = r_contours; n_max = r_max;     n_total = r_total;
        n_cursor = r_cursor;   n_hold = r_hold;     n_rep = r_rep;
        n_last_flag = r_last_flag; n_skip = r_skip; n_sum = r_sum;
        fw_en = 1'b0; fw_data = i_data_byte; xw_en = 1'b0; xw_data = r_sum; rd_en = 1'b0;
        emit = 1'b0; e_pv = 1'b0; e_err = 1'b0; e_last = 1'b0; e_on = 1'b0;
        e_x = 16'd0; e_y = 16'd0;

        if (in_acc && i_glyph_start) begin
            n_contours = i_contour_count;
            n_max = '0; n_total = '0; n_cursor = '0; n_rep = '0;
            n_sum = '0; n_skip = '0; n_hi = 1'b0;
            if (i_contour_count > MaxCnt) begin
                emit = 1'b1; e_err = 1'b1; e_last = 1'b1;
                n_state = tsgd_pkg::ST_IDLE;
            end else begin
                n_state = (i_contour_count == '0) ? tsgd_pkg::ST_ILEN : tsgd_pkg::ST_ENDS;
            end
        end else begin
            case (r_state)
                tsgd_pkg::ST_ENDS: begin
                    if (in_acc) begin
                        if (!r_hi) begin
                            n_hold = i_data_byte; n_hi = 1'b1;
                        end else begin
                            n_hi = 1'b0;
                            if (word >= MaxPts16) begin
                                emit = 1'b1; e_err = 1'b1; e_last = 1'b1;
                                n_state = tsgd_pkg::ST_IDLE;
                            end else begin
                                n_max = max_new;
                                n_contours = r_contours - 1'b1;
                                if (r_contours == tsgd_pkg::CntW'(1)) begin
                                    n_total = max_new + 1'b1;
                                    n_state = tsgd_pkg::ST_ILEN;
                                end
                            end
                        end
                    end
                end
                tsgd_pkg::ST_ILEN, tsgd_pkg::ST_SKIP: begin
                    if (in_acc) begin
                        if (r_state == tsgd_pkg::ST_ILEN && !r_hi) begin
                            n_hold = i_data_byte; n_hi = 1'b1;
                        end else begin
                            n_hi = 1'b0;
                            n_skip = (r_state == tsgd_pkg::ST_ILEN) ? word : r_skip - 1'b1;
                            if (n_skip == 16'd0) begin
                                if (r_total == '0) begin
                                    emit = 1'b1; e_last = 1'b1;
                                    n_state = tsgd_pkg::ST_IDLE;
                                end else begin
                                    n_state = tsgd_pkg::ST_FLAGS; n_cursor = '0;
                                end
                            end else begin
                                n_state = tsgd_pkg::ST_SKIP;
                            end
                        end
                    end
                end
                tsgd_pkg::ST_FLAGS: begin
                    if (in_acc) begin
                        fw_en = 1'b1; n_last_flag = i_data_byte; n_cursor = cur_inc;
                        if (i_data_byte[tsgd_pkg::FlagRepeat]) begin
                            n_state = tsgd_pkg::ST_REPCNT;
                        end else if (cur_inc >= r_total) begin
                            n_state = tsgd_pkg::ST_FETCH; n_is_y = 1'b0;
                            n_cursor = '0; n_sum = '0; n_hi = 1'b0;
                        end
                    end
                end
                tsgd_pkg::ST_REPCNT: begin
                    if (in_acc) begin
                        n_rep = i_data_byte; n_state = tsgd_pkg::ST_REPFILL;
                    end
                end
                tsgd_pkg::ST_REPFILL: begin
                    if (r_rep != 8'd0 && r_cursor < r_total) begin
                        fw_en = 1'b1; fw_data = r_last_flag;
                        n_cursor = cur_inc; n_rep = r_rep - 1'b1;
                    end else begin
                        n_rep = '0;
                        if (r_cursor >= r_total) begin
                            n_state = tsgd_pkg::ST_FETCH; n_is_y = 1'b0;
                            n_cursor = '0; n_sum = '0; n_hi = 1'b0;
                        end else begin
                            n_state = tsgd_pkg::ST_FLAGS;
                        end
                    end
                end
                tsgd_pkg::ST_FETCH: begin
                    if (r_cursor >= r_total) begin
                        if (!r_is_y) begin
                            n_is_y = 1'b1; n_cursor = '0; n_sum = '0;
                        end else begin
                            n_state = tsgd_pkg::ST_IDLE;
                        end
                    end else begin
                        rd_en = 1'b1; n_state = tsgd_pkg::ST_LOOK;
                    end
                end
                tsgd_pkg::ST_LOOK: begin
                    if (!sb && mb) begin
                        if (!r_is_y) begin
                            xw_en = 1'b1; n_cursor = cur_inc; n_state = tsgd_pkg::ST_FETCH;
                        end else if (out_free) begin
                            emit = 1'b1; e_pv = 1'b1; e_x = r_rd_x; e_y = r_sum;
                            e_on = r_rd_flag[tsgd_pkg::FlagOnCurve];
                            e_last = (cur_inc == r_total);
                            n_cursor = cur_inc; n_state = tsgd_pkg::ST_FETCH;
                        end
                    end else begin
                        n_state = tsgd_pkg::ST_DATA;
                    end
                end
                tsgd_pkg::ST_DATA: begin
                    if (in_acc) begin
                        if (!sb && !r_hi) begin
                            n_hold = i_data_byte; n_hi = 1'b1;
                        end else begin
                            n_hi = 1'b0;
                            n_sum = sb ? sum_short : sum_long;
                            if (!r_is_y) begin
                                xw_en = 1'b1; xw_data = n_sum;
                            end else begin
                                emit = 1'b1; e_pv = 1'b1; e_x = r_rd_x; e_y = n_sum;
                                e_on = r_rd_flag[tsgd_pkg::FlagOnCurve];
                                e_last = (cur_inc == r_total);
                            end
                            n_cursor = cur_inc; n_state = tsgd_pkg::ST_FETCH;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fw_en) begin
            flag_mem[r_cursor[AW-1:0]] <= fw_data;
        end
        if (rd_en) begin
            r_rd_flag <= flag_mem[r_cursor[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (xw_en) begin
            x_mem[r_cursor[AW-1:0]] <= xw_data;
        end
        if (rd_en) begin
            r_rd_x <= x_mem[r_cursor[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsgd_pkg::ST_IDLE;
            r_hi <= 1'b0; r_is_y <= 1'b0;
            r_contours <= '0; r_max <= '0; r_total <= '0; r_cursor <= '0;
            r_hold <= '0; r_rep <= '0; r_last_flag <= '0; r_skip <= '0; r_sum <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hi <= n_hi; r_is_y <= n_is_y;
            r_contours <= n_contours; r_max <= n_max; r_total <= n_total;
            r_cursor <= n_cursor; r_hold <= n_hold; r_rep <= n_rep;
            r_last_flag <= n_last_flag; r_skip <= n_skip; r_sum <= n_sum;
            if (emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_point_index  <= r_is_y && e_pv ? r_cursor[5:0] : 6'd0;
            o_x_coord      <= e_x;
            o_y_coord      <= e_y;
            o_curve_on     <= e_on;
            o_point_valid  <= e_pv;
            o_decode_error <= e_err;
            o_last_point   <= e_last;
        end
    end

    `TSGD_ASSERT_IMP(a_fill_stalls, i_clk, i_rst_n, r_state == tsgd_pkg::ST_REPFILL, o_in_stall, "input taken during repeat fill")
    `TSGD_ASSERT_IMP(a_total_range, i_clk, i_rst_n, 1'b1, r_total <= MaxTot, "point count beyond store")
    `TSGD_ASSERT_IMP(a_look_cursor, i_clk, i_rst_n, r_state == tsgd_pkg::ST_LOOK || r_state == tsgd_pkg::ST_DATA, r_cursor < r_total, "point cursor out of range")
    `TSGD_ASSERT_NEXT(a_fetch_read, i_clk, i_rst_n, r_state == tsgd_pkg::ST_FETCH && r_cursor < r_total, r_state == tsgd_pkg::ST_LOOK, "lookup did not follow fetch")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef enum logic [2:0] {
        DEC_IDLE, DEC_ENDS, DEC_ILEN, DEC_SKIP, DEC_FLAGS, DEC_REPCNT, DEC_XS, DEC_YS
    } t_dec_phase;

    typedef struct packed {
        logic [5:0]  index;
        logic [15:0] x;
        logic [15:0] y;
        logic        on;
        logic        pvalid;
        logic        err;
        logic        last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_glyph_start = 1'b0;
    logic [6:0]  i_contour_count = 7'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [5:0]  o_point_index;
    logic signed [15:0] o_x_coord;
    logic signed [15:0] o_y_coord;
    logic        o_curve_on;
    logic        o_point_valid;
    logic        o_decode_error;
    logic        o_last_point;

    truetype_simple_glyph_decoder u_top (.*);

    always #2 i_clk = ~i_clk;

    t_point     expected_points[$];
    int         error_count = 0;
    bit         idling_on = 1'b1;
    int         stall_hold = 0;
    int         items_sent = 0;

    // Decoder state mirrored by the predictor.
    t_dec_phase dp;
    logic [6:0]  contours_rem;
    logic [15:0] largest_end;
    logic [7:0]  held_byte;
    logic [15:0] skip_rem;
    logic [6:0]  num_points;
    logic [6:0]  cursor;
    logic [15:0] running_sum;
    logic [7:0]  flag_mem[64];
    logic [15:0] x_mem[64];
    bit          hi_pending;

    function automatic int draw_wait();
        if (!idling_on) return 0;
        return $urandom_range(0, 15);
    endfunction

    task automatic emit(input logic [5:0] idx, input logic [15:0] x, input logic [15:0] y,
                        input logic on, input logic pv, input logic err, input logic last);
        t_point p;
        p = '{index: idx, x: x, y: y, on: on, pvalid: pv, err: err, last: last};
        expected_points.push_back(p);
    endtask

    task automatic close_glyph(input logic err);
        emit(6'd0, 16'd0, 16'd0, 1'b0, 1'b0, err, 1'b1);
        dp = DEC_IDLE;
        hi_pending = 1'b0;
    endtask

    task automatic store_point();
        logic [5:0] c;
        c = cursor[5:0];
        if (dp == DEC_XS) x_mem[c] = running_sum;
        else emit(c, x_mem[c], running_sum, flag_mem[c][tsgd_pkg::FlagOnCurve], 1'b1, 1'b0,
                  (cursor + 7'd1) == num_points);
        cursor = cursor + 7'd1;
    endtask

    task automatic walk_byteless();
        logic [7:0] f;
        int sb;
        int mb;
        forever begin
            if (dp != DEC_XS && dp != DEC_YS) return;
            if (cursor >= num_points) begin
                if (dp == DEC_XS) begin
                    dp = DEC_YS;
                    cursor = 0;
                    running_sum = 0;
                    continue;
                end
                dp = DEC_IDLE;
                return;
            end
            f = flag_mem[cursor[5:0]];
            sb = (dp == DEC_XS) ? tsgd_pkg::FlagXShort : tsgd_pkg::FlagYShort;
            mb = (dp == DEC_XS) ? tsgd_pkg::FlagXSame : tsgd_pkg::FlagYSame;
            if (!f[sb] && f[mb]) store_point();
            else return;
        end
    endtask

    task automatic begin_coords();
        dp = DEC_XS;
        cursor = 0;
        running_sum = 0;
        hi_pending = 1'b0;
        walk_byteless();
    endtask

    task automatic predict_glyph_item(input logic start, input logic [6:0] cc,
                                      input logic [7:0] b);
        logic [15:0] e;
        logic [7:0]  f;
        logic [7:0]  cnt;
        int sb;
        int mb;
        if (start) begin
            contours_rem = cc;
            largest_end = 0;
            num_points = 0;
            cursor = 0;
            running_sum = 0;
            skip_rem = 0;
            hi_pending = 1'b0;
            if (cc > 7'd64) close_glyph(1'b1);
            else dp = (cc == 0) ? DEC_ILEN : DEC_ENDS;
            return;
        end
        case (dp)
            DEC_ENDS: begin
                if (!hi_pending) begin
                    held_byte = b;
                    hi_pending = 1'b1;
                end else begin
                    e = {held_byte, b};
                    hi_pending = 1'b0;
                    if (e >= 16'd64) close_glyph(1'b1);
                    else begin
                        if (e > largest_end) largest_end = e;
                        contours_rem = contours_rem - 7'd1;
                        if (contours_rem == 0) begin
                            num_points = largest_end[6:0] + 7'd1;
                            dp = DEC_ILEN;
                        end
                    end
                end
            end
            DEC_ILEN, DEC_SKIP: begin
                if (dp == DEC_ILEN) begin
                    if (!hi_pending) begin
                        held_byte = b;
                        hi_pending = 1'b1;
                        return;
                    end
                    hi_pending = 1'b0;
                    skip_rem = {held_byte, b};
                    dp = DEC_SKIP;
                end else begin
                    skip_rem = skip_rem - 16'd1;
                end
                if (skip_rem == 0) begin
                    if (num_points == 0) close_glyph(1'b0);
                    else begin
                        dp = DEC_FLAGS;
                        cursor = 0;
                    end
                end
            end
            DEC_FLAGS: begin
                flag_mem[cursor[5:0]] = b;
                cursor = cursor + 7'd1;
                if (b[tsgd_pkg::FlagRepeat]) dp = DEC_REPCNT;
                else if (cursor >= num_points) begin_coords();
            end
            DEC_REPCNT: begin
                f = flag_mem[cursor[5:0] - 6'd1];
                cnt = b;
                while (cnt != 0 && cursor < num_points) begin
                    flag_mem[cursor[5:0]] = f;
                    cursor = cursor + 7'd1;
                    cnt = cnt - 8'd1;
                end
                if (cursor >= num_points) begin_coords();
                else dp = DEC_FLAGS;
            end
            DEC_XS, DEC_YS: begin
                f = flag_mem[cursor[5:0]];
                sb = (dp == DEC_XS) ? tsgd_pkg::FlagXShort : tsgd_pkg::FlagYShort;
                mb = (dp == DEC_XS) ? tsgd_pkg::FlagXSame : tsgd_pkg::FlagYSame;
                if (f[sb]) begin
                    if (f[mb]) running_sum = running_sum + {8'd0, b};
                    else running_sum = running_sum - {8'd0, b};
                    store_point();
                end else if (!hi_pending) begin
                    held_byte = b;
                    hi_pending = 1'b1;
                    return;
                end else begin
                    hi_pending = 1'b0;
                    running_sum = running_sum + {held_byte, b};
                    store_point();
                end
                walk_byteless();
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic start, input logic [6:0] cc, input logic [7:0] b);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_glyph_start = start;
        i_contour_count = cc;
        i_data_byte = b;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_glyph_item(start, cc, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[k]) send_item(1'b0, 7'($urandom), bytes[k]);
    endtask

    // Builds a glyph, well-formed unless bad_end puts an out-of-range end point in or truncate cuts it short.
    task automatic send_random_glyph(input int max_pts, input bit bad_end, input bit truncate);
        logic [7:0] bytes[$];
        logic [7:0] pflags[$];
        logic [7:0] f;
        int npts;
        int nc;
        int ends;
        int ilen;
        int cnt;
        int bad_slot;
        npts = $urandom_range(1, max_pts);
        nc = $urandom_range(1, 3);
        bad_slot = $urandom_range(0, nc - 1);
        for (int c = 0; c < nc; c++) begin
            ends = (c == nc - 1) ? npts - 1 : $urandom_range(0, npts - 1);
            if (bad_end && c == bad_slot) ends = $urandom_range(64, 65535);
            bytes.push_back(ends[15:8]);
            bytes.push_back(ends[7:0]);
        end
        ilen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        bytes.push_back(8'd0);
        bytes.push_back(ilen[7:0]);
        repeat (ilen) bytes.push_back(8'($urandom));
        while (pflags.size() < npts) begin
            f = 8'($urandom);
            f[tsgd_pkg::FlagRepeat] = ($urandom_range(0, 3) == 0);
            bytes.push_back(f);
            pflags.push_back(f);
            if (f[tsgd_pkg::FlagRepeat]) begin
                cnt = $urandom_range(0, 4);
                bytes.push_back(cnt[7:0]);
                repeat (cnt) if (pflags.size() < npts) pflags.push_back(f);
            end
        end
        foreach (pflags[k]) begin
            if (pflags[k][tsgd_pkg::FlagXShort]) bytes.push_back(8'($urandom));
            else if (!pflags[k][tsgd_pkg::FlagXSame]) begin
                bytes.push_back(8'($urandom));
                bytes.push_back(8'($urandom));
            end
        end
        foreach (pflags[k]) begin
            if (pflags[k][tsgd_pkg::FlagYShort]) bytes.push_back(8'($urandom));
            else if (!pflags[k][tsgd_pkg::FlagYSame]) begin
                bytes.push_back(8'($urandom));
                bytes.push_back(8'($urandom));
            end
        end
        if (truncate) bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
        send_item(1'b1, nc[6:0], 8'($urandom));
        send_bytes(bytes);
    endtask

    task automatic test_directed_glyphs();
        // Two points: long x deltas of 0x7FFF then 0x8000, short y deltas of 255 positive and negative.
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'h00, 8'h01, 8'h00, 8'h00, 8'h25, 8'h04,
                     8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF});
        // Every point takes no delta byte, and a repeat run passes the point count.
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'h00, 8'h02, 8'h00, 8'h00, 8'h39, 8'hFF});
        // A 64-point glyph built from one repeated flag with no delta bytes.
        send_item(1'b1, 7'd2, 8'd0);
        send_bytes('{8'h00, 8'h05, 8'h00, 8'h3F, 8'h00, 8'h01, 8'hAA, 8'h39, 8'h3F});
    endtask

    task automatic test_special_cases();
        // Zero contours, with a skipped instruction byte and without one.
        send_item(1'b1, 7'd0, 8'd0);
        send_bytes('{8'h00, 8'h01, 8'h5A});
        send_item(1'b1, 7'd0, 8'd0);
        send_bytes('{8'h00, 8'h00});
        send_item(1'b1, 7'd65, 8'd0);
        send_item(1'b1, 7'd127, 8'd0);
        send_bytes('{8'h12, 8'hED});
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'h00, 8'h40});
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'hFF, 8'hFF});
        // The largest contour count is accepted, then abandoned.
        send_item(1'b1, 7'd64, 8'd0);
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h01});
        // An instruction length with a nonzero high byte, abandoned while skipping.
        send_item(1'b1, 7'd0, 8'd0);
        send_bytes('{8'h01, 8'h00});
        repeat (4) send_item(1'b0, 7'd0, 8'($urandom));
        // A new glyph abandons this one in the middle of its flags.
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'h00, 8'h03, 8'h00, 8'h00, 8'h01});
        send_item(1'b1, 7'd1, 8'd0);
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h01, 8'h02, 8'h03, 8'h04,
                     8'h05});
        send_bytes('{8'h01, 8'h02, 8'h03});
    endtask

    task automatic test_random_glyphs();
        int base;
        int pick;
        base = items_sent;
        while (items_sent - base < 130) begin
            pick = $urandom_range(0, 19);
            idling_on = ($urandom_range(0, 4) != 0);
            if (pick == 0) send_item(1'b1, 7'($urandom), 8'($urandom));
            else if (pick == 1) send_item(1'b0, 7'($urandom), 8'($urandom));
            else if (pick == 2) send_random_glyph(8, 1'b1, 1'b0);
            else if (pick == 3) send_random_glyph(8, 1'b0, 1'b1);
            else if (pick == 4) send_random_glyph(64, 1'b0, 1'b0);
            else send_random_glyph(8, 1'b0, 1'b0);
        end
        idling_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall = 1'b1;
            stall_hold--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            stall_hold = draw_wait();
            if (expected_points.size() == 0) begin
                $error("unexpected result, index %0d", o_point_index);
                error_count++;
            end else begin
                e = expected_points.pop_front();
                if (o_point_index !== e.index) begin
                    $error("point_index expected %0d actual %0d", e.index, o_point_index);
                    error_count++;
                end
                if (o_x_coord !== e.x) begin
                    $error("x_coord expected %0d actual %0d", $signed(e.x), o_x_coord);
                    error_count++;
                end
                if (o_y_coord !== e.y) begin
                    $error("y_coord expected %0d actual %0d", $signed(e.y), o_y_coord);
                    error_count++;
                end
                if (o_curve_on !== e.on) begin
                    $error("curve_on expected %0d actual %0d", e.on, o_curve_on);
                    error_count++;
                end
                if (o_point_valid !== e.pvalid) begin
                    $error("point_valid expected %0d actual %0d", e.pvalid, o_point_valid);
                    error_count++;
                end
                if (o_decode_error !== e.err) begin
                    $error("decode_error expected %0d actual %0d", e.err, o_decode_error);
                    error_count++;
                end
                if (o_last_point !== e.last) begin
                    $error("last_point expected %0d actual %0d", e.last, o_last_point);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("truetype_simple_glyph_decoder verification failed");
        $finish;
    end

    initial begin
        dp = DEC_IDLE;
        contours_rem = 0;
        largest_end = 0;
        held_byte = 0;
        skip_rem = 0;
        num_points = 0;
        cursor = 0;
        running_sum = 0;
        hi_pending = 1'b0;
        foreach (flag_mem[k]) flag_mem[k] = 0;
        foreach (x_mem[k]) x_mem[k] = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_glyphs();
        test_special_cases();
        test_random_glyphs();
        i_in_valid = 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && expected_points.size() == 0) begin
            $display("truetype_simple_glyph_decoder verification clean");
        end else begin
            $display("truetype_simple_glyph_decoder verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tsgd_pkg.sv
rtl/truetype_simple_glyph_decoder.sv
tb/testbench.sv
